// ===== design/kea_pkg.sv =====
// Shared types and constants for the Kepler eccentric anomaly solver.
package kea_pkg;

  localparam int NEWTON_STEPS_DEF = 10;

  localparam int ECC_W    = 24;
  localparam int EPOCH_W  = 32;
  localparam int MOTION_W = 36;
  localparam int ANGLE_W  = 32;
  localparam int SECS_W   = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ECC    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EPOCH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MOTION = 2'd2;

  localparam logic [ECC_W-1:0] ECC_MAX = 24'd16609443;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic              empty;
    logic [QCNT_W-1:0] count;
  } queue_stat_t;

  // pi/2 in Q1.32 and 1/(2 pi) in Q0.32
  localparam logic [32:0] HALF_PI_Q32    = 33'd6746518852;
  localparam logic [31:0] INV_TWO_PI_Q32 = 32'd683565276;
  localparam logic [30:0] ONE_Q30        = 31'd1 << 30;

  // Taylor terms: five sine terms then six cosine terms. Division by the
  // term constant is a multiply by ceil(2^S/k) then a shift by S.
  localparam int N_TERMS   = 11;
  localparam int SIN_TERMS = 5;
  localparam logic [5:0] TERM_SHIFT [N_TERMS] = '{
    6'd37, 6'd37, 6'd36, 6'd35, 6'd33,
    6'd38, 6'd37, 6'd36, 6'd35, 6'd34, 6'd31
  };
  localparam logic [31:0] TERM_RECIP [N_TERMS] = '{
    32'(((64'd1 << 37) + 64'd109) / 64'd110),
    32'(((64'd1 << 37) + 64'd71) / 64'd72),
    32'(((64'd1 << 36) + 64'd41) / 64'd42),
    32'(((64'd1 << 35) + 64'd19) / 64'd20),
    32'(((64'd1 << 33) + 64'd5) / 64'd6),
    32'(((64'd1 << 38) + 64'd131) / 64'd132),
    32'(((64'd1 << 37) + 64'd89) / 64'd90),
    32'(((64'd1 << 36) + 64'd55) / 64'd56),
    32'(((64'd1 << 35) + 64'd29) / 64'd30),
    32'(((64'd1 << 34) + 64'd11) / 64'd12),
    32'(((64'd1 << 31) + 64'd1) / 64'd2)
  };

  // restoring divider: 33-bit magnitude followed by 30 zero bits
  localparam int DIV_BITS = 63;

endpackage

// ===== design/kea_queue.sv =====
// Small register queue carrying mean anomalies from front to back.
module kea_queue (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic [kea_pkg::ANGLE_W-1:0]  din,
  input  logic                         pop,
  output logic [kea_pkg::ANGLE_W-1:0]  dout,
  output kea_pkg::queue_stat_t         stat
);

  logic [kea_pkg::ANGLE_W-1:0] mem [kea_pkg::QUEUE_DEPTH];
  logic [kea_pkg::QPTR_W-1:0]  wptr;
  logic [kea_pkg::QPTR_W-1:0]  rptr;
  logic [kea_pkg::QCNT_W-1:0]  count;
  logic                        do_pop;

  assign do_pop     = pop && (count != '0);
  assign dout       = mem[rptr];
  assign stat.empty = (count == '0);
  assign stat.count = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= din;
    end
  end

endmodule

// ===== design/kea_front.sv =====
// Front end: takes time items and forms the wrapped mean anomaly.
module kea_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  output logic                               full,
  input  logic signed [kea_pkg::SECS_W-1:0]  secs,
  input  logic [kea_pkg::EPOCH_W-1:0]        epoch,
  input  logic [kea_pkg::MOTION_W-1:0]       motion,
  input  kea_pkg::queue_stat_t               qstat,
  output logic                               q_push,
  output logic [kea_pkg::ANGLE_W-1:0]        q_m
);

  logic               accept;
  logic               v1;
  logic               v2;
  logic signed [50:0] pl;
  logic signed [50:0] ph;
  logic [47:0]        m48;
  logic [31:0]        m2;
  logic [kea_pkg::QCNT_W:0] credit;

  // items in flight count against the queue so the pipe never stalls
  assign credit = {1'b0, qstat.count} + (kea_pkg::QCNT_W+1)'(v1)
                + (kea_pkg::QCNT_W+1)'(v2);
  assign full   = credit >= (kea_pkg::QCNT_W+1)'(kea_pkg::QUEUE_DEPTH);
  assign accept = push && !full;

  // mean motion split in two 18-bit halves; product kept modulo 2^48
  assign m48 = {epoch, 16'h0} + pl[47:0] + {ph[29:0], 18'h0};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    pl <= $signed({1'b0, motion[17:0]}) * secs;
    ph <= $signed({1'b0, motion[35:18]}) * secs;
    m2 <= m48[47:16];
  end

  assign q_push = v2;
  assign q_m    = m2;

endmodule

// ===== design/kea_newton.sv =====
// Back end: Newton iteration on Kepler's equation with a shared multiplier
// and a bit-serial divider, plus the result register.
module kea_newton #(
  parameter int NEWTON_STEPS = kea_pkg::NEWTON_STEPS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  kea_pkg::queue_stat_t          qstat,
  input  logic [kea_pkg::ANGLE_W-1:0]   q_m,
  output logic                          q_pop,
  input  logic [kea_pkg::ECC_W-1:0]     ecc,
  output logic                          res_valid,
  input  logic                          res_pop,
  output logic [kea_pkg::ANGLE_W-1:0]   res_e,
  output logic [kea_pkg::ANGLE_W-1:0]   res_m
);

  localparam int NS_W = (NEWTON_STEPS > 1) ? $clog2(NEWTON_STEPS) : 1;

  typedef enum logic [14:0] {
    ST_IDLE = 15'd1 << 0,
    ST_X    = 15'd1 << 1,
    ST_X2   = 15'd1 << 2,
    ST_X2L  = 15'd1 << 3,
    ST_TMUL = 15'd1 << 4,
    ST_TDIV = 15'd1 << 5,
    ST_TSUB = 15'd1 << 6,
    ST_SFIN = 15'd1 << 7,
    ST_SLAT = 15'd1 << 8,
    ST_ES   = 15'd1 << 9,
    ST_EC   = 15'd1 << 10,
    ST_TERM = 15'd1 << 11,
    ST_DSET = 15'd1 << 12,
    ST_DIV  = 15'd1 << 13,
    ST_DONE = 15'd1 << 14
  } state_t;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  state_t      state;
  state_t      state_next;

  logic [31:0] m_r;
  logic [31:0] e_r;
  logic [1:0]  quad_r;
  logic        swap_r;
  logic [63:0] prod;
  logic [32:0] mul_a;
  logic [31:0] mul_b;
  logic [29:0] x_r;
  logic [29:0] x2_r;
  logic [30:0] t_r;
  logic [3:0]  ti;
  logic [30:0] s_oct;
  logic [30:0] c_mag_r;
  logic        c_neg_r;
  logic        s_neg_r;
  logic [30:0] es_r;
  logic [30:0] ecm_r;
  logic [62:0] dvd_r;
  logic [31:0] rem_r;
  logic [31:0] quo_r;
  logic [31:0] den_r;
  logic        neg_r;
  logic [5:0]  dcnt;
  logic [NS_W-1:0] ns;

  logic [23:0] ecc_c;
  logic [29:0] f;
  logic [29:0] r;
  logic [30:0] ps;
  logic [30:0] pc;
  logic [30:0] s_mag;
  logic        s_neg;
  logic [30:0] c_mag;
  logic        c_neg;
  logic [31:0] diff;
  logic [31:0] term;
  logic [33:0] num;
  logic [33:0] mag;
  logic [31:0] den;
  logic [32:0] trial;
  logic        ge;
  logic [32:0] rem_next;
  logic [31:0] quo_next;
  logic [30:0] t_next;
  logic        load_res;

  assign ecc_c = (ecc > kea_pkg::ECC_MAX) ? kea_pkg::ECC_MAX : ecc;

  // octant reduction of the current estimate
  assign f = e_r[29:0];
  assign r = f[29] ? 30'((31'd1 << 30) - {1'b0, f}) : f;

  // octant results to quadrant, sign and magnitude
  assign ps = swap_r ? t_r : s_oct;
  assign pc = swap_r ? s_oct : t_r;

  always_comb begin
    unique case (quad_r)
      QUAD_0: begin
        s_mag = ps; s_neg = 1'b0; c_mag = pc; c_neg = 1'b0;
      end
      QUAD_1: begin
        s_mag = pc; s_neg = 1'b0; c_mag = ps; c_neg = 1'b1;
      end
      QUAD_2: begin
        s_mag = ps; s_neg = 1'b1; c_mag = pc; c_neg = 1'b1;
      end
      QUAD_3: begin
        s_mag = pc; s_neg = 1'b1; c_mag = ps; c_neg = 1'b0;
      end
      default: begin
        s_mag = ps; s_neg = 1'b0; c_mag = pc; c_neg = 1'b0;
      end
    endcase
  end

  // numerator and denominator of the Newton step
  assign diff = m_r - e_r;
  assign term = prod[61:30];
  assign num  = {{2{diff[31]}}, diff}
              + (s_neg_r ? (34'd0 - {2'b0, term}) : {2'b0, term});
  assign mag  = num[33] ? (34'd0 - num) : num;
  assign den  = c_neg_r ? ({1'b0, kea_pkg::ONE_Q30} + {1'b0, ecm_r})
                        : ({1'b0, kea_pkg::ONE_Q30} - {1'b0, ecm_r});

  // one quotient bit per cycle
  assign trial    = {rem_r, dvd_r[62]};
  assign ge       = trial >= {1'b0, den_r};
  assign rem_next = ge ? (trial - {1'b0, den_r}) : trial;
  assign quo_next = {quo_r[30:0], ge};

  assign t_next = kea_pkg::ONE_Q30 - 31'(prod >> kea_pkg::TERM_SHIFT[ti]);

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_X: begin
        mul_a = {3'b0, r};
        mul_b = kea_pkg::HALF_PI_Q32[31:0];
      end
      ST_X2: begin
        mul_a = {3'b0, prod[61:32]};
        mul_b = {2'b0, prod[61:32]};
      end
      ST_TMUL: begin
        mul_a = {3'b0, x2_r};
        mul_b = {1'b0, t_r};
      end
      ST_TDIV: begin
        mul_a = {3'b0, prod[59:30]};
        mul_b = kea_pkg::TERM_RECIP[ti];
      end
      ST_SFIN: begin
        mul_a = {3'b0, x_r};
        mul_b = {1'b0, t_r};
      end
      ST_ES: begin
        mul_a = {2'b0, s_mag};
        mul_b = {8'b0, ecc_c};
      end
      ST_EC: begin
        mul_a = {2'b0, c_mag_r};
        mul_b = {8'b0, ecc_c};
      end
      ST_TERM: begin
        mul_a = {2'b0, es_r};
        mul_b = kea_pkg::INV_TWO_PI_Q32;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // the pi/2 constant has its top bit set; add that partial product apart
  logic [63:0] mul_p;
  assign mul_p = {31'b0, mul_a} * {32'b0, mul_b}
               + ((state == ST_X) ? ({31'b0, mul_a} << 32) : 64'd0);

  assign load_res = (state == ST_DONE) && (!res_valid || res_pop);
  assign q_pop    = (state == ST_IDLE) && !qstat.empty;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (!qstat.empty) state_next = ST_X;
      ST_X:    state_next = ST_X2;
      ST_X2:   state_next = ST_X2L;
      ST_X2L:  state_next = ST_TMUL;
      ST_TMUL: state_next = ST_TDIV;
      ST_TDIV: state_next = ST_TSUB;
      ST_TSUB: begin
        if (ti == 4'(kea_pkg::SIN_TERMS - 1)) begin
          state_next = ST_SFIN;
        end else if (ti == 4'(kea_pkg::N_TERMS - 1)) begin
          state_next = ST_ES;
        end else begin
          state_next = ST_TMUL;
        end
      end
      ST_SFIN: state_next = ST_SLAT;
      ST_SLAT: state_next = ST_TMUL;
      ST_ES:   state_next = ST_EC;
      ST_EC:   state_next = ST_TERM;
      ST_TERM: state_next = ST_DSET;
      ST_DSET: state_next = ST_DIV;
      ST_DIV: begin
        if (dcnt == 6'(kea_pkg::DIV_BITS - 1)) begin
          state_next = (ns == NS_W'(NEWTON_STEPS - 1)) ? ST_DONE : ST_X;
        end
      end
      ST_DONE: if (load_res) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_res) begin
        res_valid <= 1'b1;
      end else if (res_pop) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_p;
    if (load_res) begin
      res_e <= e_r;
      res_m <= m_r;
    end
    unique case (state)
      ST_IDLE: begin
        m_r <= q_m;
        e_r <= q_m;
        ns  <= '0;
      end
      ST_X: begin
        quad_r <= e_r[31:30];
        swap_r <= f[29];
      end
      ST_X2: x_r <= prod[61:32];
      ST_X2L: begin
        x2_r <= prod[59:30];
        t_r  <= kea_pkg::ONE_Q30;
        ti   <= '0;
      end
      ST_TSUB: begin
        t_r <= t_next;
        ti  <= ti + 1'b1;
      end
      ST_SLAT: begin
        s_oct <= prod[60:30];
        t_r   <= kea_pkg::ONE_Q30;
      end
      ST_ES: begin
        c_mag_r <= c_mag;
        c_neg_r <= c_neg;
        s_neg_r <= s_neg;
      end
      ST_EC:   es_r  <= prod[54:24];
      ST_TERM: ecm_r <= prod[54:24];
      ST_DSET: begin
        neg_r <= num[33];
        dvd_r <= {mag[32:0], 30'b0};
        den_r <= den;
        rem_r <= '0;
        quo_r <= '0;
        dcnt  <= '0;
      end
      ST_DIV: begin
        rem_r <= rem_next[31:0];
        quo_r <= quo_next;
        dvd_r <= {dvd_r[61:0], 1'b0};
        dcnt  <= dcnt + 1'b1;
        if (dcnt == 6'(kea_pkg::DIV_BITS - 1)) begin
          e_r <= e_r + (neg_r ? (32'd0 - quo_next) : quo_next);
          ns  <= ns + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== design/kepler_eccentric_anomaly_solver_top.sv =====
// Top level of the Kepler eccentric anomaly solver.
//
// Input channel: an elapsed time in seconds is transferred when push is
// high and full is low. Result channel: while empty is low the oldest
// result (eccentric and mean anomaly, Q0.32 turns) is on the ports; it is
// transferred when pop is high.
// Configuration: write_enable with write_index 0 (eccentricity), 1 (epoch
// mean anomaly) or 2 (mean motion); other indexes are ignored.
// The front end forms the mean anomaly in a two-stage multiply pipeline
// and drops it into a four-entry queue. The back end solves one item at a
// time: each Newton step runs the sine/cosine series on the shared
// multiplier, then the bit-serial divider, and an item gets NEWTON_STEPS
// steps before its result is offered.
// The front keeps taking items until the queue and its pipeline hold four.
// A stalled result waits in the output register while the back end holds
// the next finished item. Reset clears the registers, queue and result.
module kepler_eccentric_anomaly_solver_top #(
  parameter int NEWTON_STEPS = kea_pkg::NEWTON_STEPS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic signed [kea_pkg::SECS_W-1:0]   elapsed_seconds,
  output logic                                empty,
  input  logic                                pop,
  output logic [kea_pkg::ANGLE_W-1:0]         ecc_anomaly,
  output logic [kea_pkg::ANGLE_W-1:0]         mean_anomaly,
  input  logic                                write_enable,
  input  logic [kea_pkg::CFG_IDX_W-1:0]       write_index,
  input  logic [kea_pkg::MOTION_W-1:0]        write_data
);

  logic [kea_pkg::ECC_W-1:0]    ecc_r;
  logic [kea_pkg::EPOCH_W-1:0]  epoch_r;
  logic [kea_pkg::MOTION_W-1:0] motion_r;

  kea_pkg::queue_stat_t         qstat;
  logic                         f_push;
  logic [kea_pkg::ANGLE_W-1:0]  f_m;
  logic                         q_pop;
  logic [kea_pkg::ANGLE_W-1:0]  q_m;
  logic                         res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      ecc_r    <= '0;
      epoch_r  <= '0;
      motion_r <= '0;
    end else if (write_enable) begin
      unique case (write_index)
        kea_pkg::REG_ECC:    ecc_r    <= write_data[kea_pkg::ECC_W-1:0];
        kea_pkg::REG_EPOCH:  epoch_r  <= write_data[kea_pkg::EPOCH_W-1:0];
        kea_pkg::REG_MOTION: motion_r <= write_data;
        default: begin
        end
      endcase
    end
  end

  kea_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .secs   (elapsed_seconds),
    .epoch  (epoch_r),
    .motion (motion_r),
    .qstat  (qstat),
    .q_push (f_push),
    .q_m    (f_m)
  );

  kea_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (f_push),
    .din  (f_m),
    .pop  (q_pop),
    .dout (q_m),
    .stat (qstat)
  );

  kea_newton #(
    .NEWTON_STEPS (NEWTON_STEPS)
  ) u_newton (
    .clk       (clk),
    .rst       (rst),
    .qstat     (qstat),
    .q_m       (q_m),
    .q_pop     (q_pop),
    .ecc       (ecc_r),
    .res_valid (res_valid),
    .res_pop   (pop),
    .res_e     (ecc_anomaly),
    .res_m     (mean_anomaly)
  );

  assign empty = !res_valid;

  // the credit scheme must keep the queue from overflowing
  assert property (@(posedge clk) disable iff (rst)
    !(f_push && (qstat.count == kea_pkg::QCNT_W'(kea_pkg::QUEUE_DEPTH))))
    else $error("queue overflow");

  // queue never reports more than its depth
  assert property (@(posedge clk) disable iff (rst)
    qstat.count <= kea_pkg::QCNT_W'(kea_pkg::QUEUE_DEPTH))
    else $error("queue count out of range");

  // a reset leaves no result waiting
  assert property (@(posedge clk) rst |=> empty)
    else $error("result present after reset");

  // back end only takes an item the queue holds
  assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !qstat.empty)
    else $error("pop from empty queue");

endmodule
